// ----- sv/dpaq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpaq_pkg
// Shared types and constants for the pending address queue with recent
// duplicate suppression.
// ----------------------------------------------------------------------------
package dpaq_pkg;

  localparam int DEPTH    = 256;
  localparam int LOOKBACK = 8;
  localparam int ADDR_W   = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int STAT_W   = 3;

  // operation codes
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_POP     = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_STORED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP         = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO        = 3'd2;
  localparam logic [STAT_W-1:0] ST_STORED_DROP = 3'd3;
  localparam logic [STAT_W-1:0] ST_POPPED      = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] popped_address;
    logic [CNT_W-1:0]  remaining;
  } result_t;

  // slot index with wrap at DEPTH; sum is below 2*DEPTH
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] w;
    w = (s >= (CNT_W + 1)'(DEPTH)) ? s - (CNT_W + 1)'(DEPTH) : s;
    return w[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/dedup_pending_address_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_pending_address_queue_core
// FIFO of pending addresses that drops zero and recently queued duplicates.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An observe reports
// its result on the result port, with done high, in the cycle after
// acceptance. A pop of a non-empty queue waits in state S_POP, with busy
// high, for the registered read of the queue memory; the result is then
// registered from S_POP. An empty pop reports like an observe. Each result
// is shown for exactly one cycle and cannot be stalled, so the receiver
// must take it when done is high.
module dedup_pending_address_queue_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire dpaq_pkg::item_t   item,
  output logic                   done,
  output dpaq_pkg::result_t      result
);
  import dpaq_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              done_next;
  result_t           result_next;

  logic              accept;
  logic              is_zero, hit, full, empty;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  waddr, tail, head_inc;
  logic [ADDR_W-1:0] rdata;

  assign accept   = start && !busy;
  assign is_zero  = (item.address == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign tail     = wrap_idx({1'b0, CNT_W'(head)} + {1'b0, count});
  assign head_inc = wrap_idx({1'b0, CNT_W'(head)} + (CNT_W + 1)'(1));

  assign ram_we = accept && (item.operation == OP_OBSERVE) && !is_zero && !hit;
  assign waddr  = full ? head : tail;
  assign ram_re = accept && (item.operation == OP_POP) && !empty;

  dpaq_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (item.address),
    .re    (ram_re),
    .raddr (head),
    .rdata (rdata)
  );

  dpaq_window u_window (
    .clk       (clk),
    .push      (ram_we),
    .push_addr (item.address),
    .count     (count),
    .query     (item.address),
    .hit       (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (ram_re) state_next = S_POP;
      S_POP:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy        = (state == S_POP);
    head_next   = head;
    count_next  = count;
    done_next   = 1'b0;
    result_next = result;
    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next                  = 1'b1;
          result_next.popped_address = '0;
          if (item.operation == OP_OBSERVE) begin
            if (is_zero) begin
              result_next.status = ST_ZERO;
            end else if (hit) begin
              result_next.status = ST_DUP;
            end else if (!full) begin
              count_next         = count + CNT_W'(1);
              result_next.status = ST_STORED;
            end else begin
              head_next          = head_inc;
              result_next.status = ST_STORED_DROP;
            end
            result_next.remaining = count_next;
          end else begin
            // a non-empty pop finishes once the memory read returns
            done_next             = empty;
            result_next.status    = ST_EMPTY;
            result_next.remaining = '0;
          end
        end
      end
      S_POP: begin
        head_next                  = head_inc;
        count_next                 = count - CNT_W'(1);
        done_next                  = 1'b1;
        result_next.status         = ST_POPPED;
        result_next.popped_address = rdata;
        result_next.remaining      = count_next;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

// ----- sv/dpaq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpaq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dpaq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dpaq_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpaq_window
// Recent-append window: the last appended addresses, newest first, compared
// in parallel against a query. Only the newest min(count, LOOKBACK) count.
// ----------------------------------------------------------------------------
module dpaq_window (
  input  wire logic                         clk,
  input  wire logic                         push,
  input  wire logic [dpaq_pkg::ADDR_W-1:0]  push_addr,
  input  wire logic [dpaq_pkg::CNT_W-1:0]   count,
  input  wire logic [dpaq_pkg::ADDR_W-1:0]  query,
  output logic                              hit
);
  import dpaq_pkg::*;

  logic [ADDR_W-1:0] win [LOOKBACK];
  logic [LOOKBACK-1:0] match;

  always_ff @(posedge clk) begin
    if (push) begin
      win[0] <= push_addr;
      for (int i = 1; i < LOOKBACK; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  // entry i holds a queued address only while i < count
  always_comb begin
    for (int i = 0; i < LOOKBACK; i++) begin
      match[i] = (CNT_W'(i) < count) && (win[i] == query);
    end
  end

  assign hit = |match;

endmodule
`default_nettype wire

// ----- sv/dpaq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpaq_checker
// Port-level checks for the pending address queue, bound to the top level.
// ----------------------------------------------------------------------------
module dpaq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire dpaq_pkg::item_t   item,
  input wire logic              done,
  input wire dpaq_pkg::result_t result
);
  import dpaq_pkg::*;

  // an accepted observe always reports in the next cycle
  a_observe_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == OP_OBSERVE) |=> done)
    else $error("observe transaction produced no result");

  // the pop wait is followed by a popped result with busy low
  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done && result.status == ST_POPPED))
    else $error("pop wait did not end in a popped result");

  // only a pop result carries an address
  a_popped_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_POPPED) |-> (result.popped_address == '0))
    else $error("non-pop result carries an address");

  // an eviction happens only on a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_STORED_DROP) |-> (result.remaining == CNT_W'(DEPTH)))
    else $error("drop reported on a queue that is not full");

endmodule

bind dedup_pending_address_queue_core dpaq_checker u_dpaq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire
